### hw/rtl/per_source_query_flood_limiter_core_defines.svh
// Assertion macros shared by the flood limiter checker.
// Depends on nothing; the including module provides clock and reset.
`ifndef PER_SOURCE_QUERY_FLOOD_LIMITER_CORE_DEFINES_SVH
`define PER_SOURCE_QUERY_FLOOD_LIMITER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PQFL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define PQFL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/pqfl_pkg.sv
// Shared types and constants of the per-source query flood limiter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pqfl_pkg;

   localparam int ADDR_W     = 32;
   localparam int COUNT_W    = 17;
   localparam int THRESH_W   = 16;
   localparam int TICK_W     = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [COUNT_W-1:0]  COUNT_MAX = 17'h1FFFF;
   localparam logic [TICK_W-1:0]   TICK_MAX  = 16'hFFFF;

   localparam logic [THRESH_W-1:0] FLOOD_THRESHOLD_RESET = 16'd350;
   localparam logic [TICK_W-1:0]   WINDOW_TICKS_RESET    = 16'd6000;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOD_THRESHOLD = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_TICKS    = 4'd1;

   typedef enum logic {
      KIND_QUERY = 1'b0,
      KIND_TICK  = 1'b1
   } req_kind_type;

   // outcome of the table lookup, passed from lookup stage to update stage
   typedef struct packed {
      req_kind_type kind;
      logic         hit;
      logic         alloc;
      logic         untracked;
      logic         clear;
   } lookup_type;

   typedef struct packed {
      logic               verdict;
      logic               ban_now;
      logic               untracked;
      logic               window_cleared;
      logic [COUNT_W-1:0] hit_count;
   } result_type;

endpackage

`default_nettype wire

### hw/rtl/pqfl_match.sv
// Source address lookup: address CAM, valid bits, fill counter and tick counter.
// Depends on pqfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pqfl_match import pqfl_pkg::*; #(
   parameter int TABLE_DEPTH = 64,
   localparam int IDX_W  = $clog2(TABLE_DEPTH),
   localparam int FILL_W = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                a_fire,
   input  req_kind_type        a_kind,
   input  logic [ADDR_W-1:0]   a_addr,
   input  logic [TICK_W-1:0]   window_ticks,
   output lookup_type          look,
   output logic [IDX_W-1:0]    look_idx
);

   logic [ADDR_W-1:0]      addr_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [FILL_W-1:0]      fill_ff;
   logic [TICK_W-1:0]      tick_ff;

   logic [TABLE_DEPTH-1:0] match;
   logic [IDX_W-1:0]       match_idx;
   logic                   any_match;
   logic                   full;
   logic                   is_query;
   logic [TICK_W-1:0]      tick_in;
   logic                   window_end;

   // parallel compare; at most one entry can hold a given address
   always_comb begin
      match_idx = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         match[i] = valid_ff[i] && (addr_mem[i] == a_addr);
         if (match[i]) begin
            match_idx = match_idx | IDX_W'(i);
         end
      end
   end

   // entries fill from the bottom, so the fill count is the lowest free slot
   assign any_match  = |match;
   assign full       = (fill_ff == FILL_W'(TABLE_DEPTH));
   assign is_query   = (a_kind == KIND_QUERY);
   assign tick_in    = (tick_ff == TICK_MAX) ? tick_ff : tick_ff + TICK_W'(1);
   assign window_end = (tick_in >= window_ticks);

   always_comb begin
      look.kind      = a_kind;
      look.hit       = is_query && any_match;
      look.alloc     = is_query && !any_match && !full;
      look.untracked = is_query && !any_match && full;
      look.clear     = !is_query && window_end;
      look_idx       = any_match ? match_idx : fill_ff[IDX_W-1:0];
   end

   // valid bits, fill count and window tick counter
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff  <= '0;
         tick_ff  <= '0;
      end else if (a_fire) begin
         if (look.clear) begin
            valid_ff <= '0;
            fill_ff  <= '0;
            tick_ff  <= '0;
         end else if (!is_query) begin
            tick_ff <= tick_in;
         end else if (look.alloc) begin
            valid_ff[fill_ff[IDX_W-1:0]] <= 1'b1;
            fill_ff                      <= fill_ff + FILL_W'(1);
         end
      end
   end

   // address store, written on allocation
   always_ff @(posedge clock) begin
      if (a_fire && look.alloc) begin
         addr_mem[fill_ff[IDX_W-1:0]] <= a_addr;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/pqfl_update.sv
// Update stage: count memory, ban bits, bypass of the count being written, result.
// Depends on pqfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pqfl_update import pqfl_pkg::*; #(
   parameter int TABLE_DEPTH = 64,
   localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                a_fire,
   input  lookup_type          look,
   input  logic [IDX_W-1:0]    look_idx,
   input  logic [THRESH_W-1:0] flood_threshold,
   input  logic                r_en,
   output logic                b_ready,
   output logic                res_valid,
   output result_type          res
);

   logic [COUNT_W-1:0]     count_mem [TABLE_DEPTH];
   logic                   b_valid_ff;
   lookup_type             b_look_ff;
   logic [IDX_W-1:0]       b_idx_ff;
   logic [COUNT_W-1:0]     rd_count_ff;
   logic                   fwd_ff;
   logic [COUNT_W-1:0]     fwd_count_ff;
   logic [TABLE_DEPTH-1:0] banned_ff;

   logic                   b_fire;
   logic [COUNT_W-1:0]     cur_count;
   logic                   banned_rd;
   logic                   wr_en;
   logic [COUNT_W-1:0]     wr_count;
   logic                   set_ban;
   logic                   fwd;

   assign b_fire    = b_valid_ff && r_en;
   assign b_ready   = !b_valid_ff || r_en;
   assign res_valid = b_valid_ff;

   // count as stored, or as the previous item writes it at this same edge
   assign cur_count = fwd_ff ? fwd_count_ff : rd_count_ff;
   assign banned_rd = banned_ff[b_idx_ff];

   // result and write-back for the item held in this stage
   always_comb begin
      res                = '0;
      res.window_cleared = b_look_ff.clear;
      wr_en              = 1'b0;
      wr_count           = COUNT_W'(1);
      set_ban            = 1'b0;
      if (b_look_ff.hit) begin
         if (banned_rd) begin
            res.verdict   = 1'b1;
            res.hit_count = cur_count;
         end else begin
            set_ban       = (cur_count >= COUNT_W'(flood_threshold));
            wr_en         = 1'b1;
            wr_count      = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_W'(1);
            res.ban_now   = set_ban;
            res.hit_count = wr_count;
         end
      end else if (b_look_ff.alloc) begin
         wr_en         = 1'b1;
         res.hit_count = wr_count;
      end else if (b_look_ff.untracked) begin
         res.untracked = 1'b1;
      end
   end

   // next item hits the entry this item writes: take the new count directly
   assign fwd = b_fire && wr_en && look.hit && (b_idx_ff == look_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (a_fire) begin
         b_look_ff    <= look;
         b_idx_ff     <= look_idx;
         fwd_ff       <= fwd;
         fwd_count_ff <= wr_count;
      end
   end

   // count memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (b_fire && wr_en) begin
         count_mem[b_idx_ff] <= wr_count;
      end
      if (a_fire) begin
         rd_count_ff <= count_mem[look_idx];
      end
   end

   // ban bits; a window clear from the later item wins over a ban set
   always_ff @(posedge clock) begin
      if (reset) begin
         banned_ff <= '0;
      end else if (a_fire && look.clear) begin
         banned_ff <= '0;
      end else if (b_fire && set_ban) begin
         banned_ff[b_idx_ff] <= 1'b1;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/per_source_query_flood_limiter_core.sv
// Per-source query flood limiter: top level with input, output and config registers.
// Depends on pqfl_pkg, pqfl_match and pqfl_update.
//
// Usage
//   req channel: one transfer per query (req_type 0, req_source_addr set) or per
//   millisecond tick (req_type 1). rsp channel: exactly one result per request,
//   in request order. csr channel: writes flood_threshold (index 0) and
//   window_ticks (index 1); other indexes are ignored, csr_ready is always high.
//   Path: a result reaches rsp_valid through the input register, the CAM lookup
//   into the update stage (the count memory's registered read), then the count
//   update into the output register.
//   Throughput: one item per cycle unless rsp_ready stalls the output; the lookup
//   and update stages forward the count being written to the next item.
//   Reset: table empty, no bans, tick counter zero, registers at 350 and 6000;
//   no clearing pass, the first request may follow reset at once.
//   Stall: while rsp_ready is low the result holds; the pipeline fills its
//   two free stages and then lowers req_ready.
`timescale 1ns / 1ps
`default_nettype none

module per_source_query_flood_limiter_core import pqfl_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic [ADDR_W-1:0]     req_source_addr,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_verdict,
   output logic                  rsp_ban_now,
   output logic                  rsp_untracked,
   output logic                  rsp_window_cleared,
   output logic [COUNT_W-1:0]    rsp_hit_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic [THRESH_W-1:0] flood_threshold_ff;
   logic [TICK_W-1:0]   window_ticks_ff;
   logic                a_valid_ff;
   req_kind_type        a_kind_ff;
   logic [ADDR_W-1:0]   a_addr_ff;
   logic                rsp_valid_ff;
   result_type          rsp_res_ff;

   logic                r_en;
   logic                a_en;
   logic                a_fire;
   logic                b_ready;
   logic                b_valid;
   lookup_type          look;
   logic [IDX_W-1:0]    look_idx;
   result_type          res;

   // stage enables
   assign r_en      = !rsp_valid_ff || rsp_ready;
   assign a_en      = !a_valid_ff || b_ready;
   assign a_fire    = a_valid_ff && b_ready;
   assign req_ready = a_en;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         flood_threshold_ff <= FLOOD_THRESHOLD_RESET;
         window_ticks_ff    <= WINDOW_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FLOOD_THRESHOLD: flood_threshold_ff <= csr_wdata;
            CSR_WINDOW_TICKS:    window_ticks_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_en) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         a_kind_ff <= req_kind_type'(req_type);
         a_addr_ff <= req_source_addr;
      end
   end

   pqfl_match #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_match (
      .clock        (clock),
      .reset        (reset),
      .a_fire       (a_fire),
      .a_kind       (a_kind_ff),
      .a_addr       (a_addr_ff),
      .window_ticks (window_ticks_ff),
      .look         (look),
      .look_idx     (look_idx)
   );

   pqfl_update #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_update (
      .clock           (clock),
      .reset           (reset),
      .a_fire          (a_fire),
      .look            (look),
      .look_idx        (look_idx),
      .flood_threshold (flood_threshold_ff),
      .r_en            (r_en),
      .b_ready         (b_ready),
      .res_valid       (b_valid),
      .res             (res)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (r_en) begin
         rsp_valid_ff <= b_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (b_valid && r_en) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_verdict        = rsp_res_ff.verdict;
   assign rsp_ban_now        = rsp_res_ff.ban_now;
   assign rsp_untracked      = rsp_res_ff.untracked;
   assign rsp_window_cleared = rsp_res_ff.window_cleared;
   assign rsp_hit_count      = rsp_res_ff.hit_count;

endmodule

`default_nettype wire

### hw/rtl/pqfl_checker.sv
// Port-level checks of the flood limiter result channel, bound to the top level.
// Depends on pqfl_pkg and per_source_query_flood_limiter_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "per_source_query_flood_limiter_core_defines.svh"

module pqfl_checker import pqfl_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_verdict,
   input wire logic               rsp_ban_now,
   input wire logic               rsp_untracked,
   input wire logic               rsp_window_cleared,
   input wire logic [COUNT_W-1:0] rsp_hit_count
);

   // stalled result holds
   `PQFL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit_count) && $stable(rsp_verdict), "result changed while stalled")

   // pipeline is empty right after reset
   `PQFL_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_valid, "result right after reset")

   // a dropped or untracked query never bans and never clears the window
   `PQFL_ASSERT_NOW(a_drop_excl, rsp_valid && (rsp_verdict || rsp_untracked), !rsp_ban_now && !rsp_window_cleared, "drop or untracked result with ban or clear")

   // a newly banned source has a nonzero count after increment and is not dropped
   `PQFL_ASSERT_NOW(a_ban_count, rsp_valid && rsp_ban_now, rsp_hit_count != '0 && !rsp_verdict, "ban with zero count or drop")

endmodule

bind per_source_query_flood_limiter_core pqfl_checker u_pqfl_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_verdict        (rsp_verdict),
   .rsp_ban_now        (rsp_ban_now),
   .rsp_untracked      (rsp_untracked),
   .rsp_window_cleared (rsp_window_cleared),
   .rsp_hit_count      (rsp_hit_count)
);

`default_nettype wire

### test/tb_per_source_query_flood_limiter_core.sv
// Self-checking testbench for per_source_query_flood_limiter_core: randomized requests,
// result stalls and register writes, each result checked against a cycle-free predictor.
// Depends on pqfl_pkg and the per_source_query_flood_limiter_core RTL.
`timescale 1ns / 1ps

module tb_per_source_query_flood_limiter_core;
   import pqfl_pkg::*;

   localparam int TABLE_DEPTH  = 64;
   localparam int LIMIT_CYCLES = 1_500_000;
   localparam int POOL_MAX     = 128;
   localparam int PHASE_ITEMS  = 280;

   // index with no register behind it, writes must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 4'd15;

   typedef struct packed {
      req_kind_type      kind;
      logic [ADDR_W-1:0] addr;
   } query_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_type = 1'b0;
   logic [ADDR_W-1:0]     req_source_addr = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_verdict;
   logic                  rsp_ban_now;
   logic                  rsp_untracked;
   logic                  rsp_window_cleared;
   logic [COUNT_W-1:0]    rsp_hit_count;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state: limiter table, tick counter and register shadows
   logic [ADDR_W-1:0]   src_addr   [TABLE_DEPTH];
   logic [COUNT_W-1:0]  src_count  [TABLE_DEPTH];
   logic                src_valid  [TABLE_DEPTH];
   logic                src_banned [TABLE_DEPTH];
   logic [TICK_W-1:0]   ticks_seen;
   logic [THRESH_W-1:0] limit_threshold;
   logic [TICK_W-1:0]   limit_window;

   query_item_type req_backlog[$];
   result_type     due_verdicts[$];
   result_type     due_head;

   int cycle_count = 0;
   int mismatch_count = 0;
   int send_wait_max = 18;
   int sink_wait_max = 18;
   int hold_cycles = 0;
   int stall_cycles = 0;

   logic [ADDR_W-1:0] addr_pool [POOL_MAX];
   int pool_size;

   per_source_query_flood_limiter_core #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_source_addr(req_source_addr),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_verdict(rsp_verdict),
      .rsp_ban_now(rsp_ban_now),
      .rsp_untracked(rsp_untracked),
      .rsp_window_cleared(rsp_window_cleared),
      .rsp_hit_count(rsp_hit_count),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("per_source_query_flood_limiter_core verification failed");
         $finish;
      end
   end

   // expected verdict for one request; updates the predictor state
   function automatic result_type judge_request(input req_kind_type kind,
                                                input logic [ADDR_W-1:0] addr);
      result_type verdict_out;
      int hit_slot;
      int free_slot;
      int i;
      verdict_out = '0;
      if (kind == KIND_TICK) begin
         if (ticks_seen != TICK_MAX) ticks_seen = ticks_seen + 1'b1;
         if (ticks_seen >= limit_window) begin
            for (i = 0; i < TABLE_DEPTH; i++) begin
               src_valid[i] = 1'b0;
               src_banned[i] = 1'b0;
            end
            ticks_seen = '0;
            verdict_out.window_cleared = 1'b1;
         end
      end else begin
         hit_slot = -1;
         free_slot = -1;
         for (i = 0; i < TABLE_DEPTH; i++) begin
            if (src_valid[i]) begin
               if (hit_slot < 0 && src_addr[i] == addr) hit_slot = i;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         if (hit_slot >= 0) begin
            if (src_banned[hit_slot]) begin
               verdict_out.verdict = 1'b1;
            end else begin
               if (src_count[hit_slot] >= {1'b0, limit_threshold}) begin
                  src_banned[hit_slot] = 1'b1;
                  verdict_out.ban_now = 1'b1;
               end
               if (src_count[hit_slot] != COUNT_MAX)
                  src_count[hit_slot] = src_count[hit_slot] + 1'b1;
            end
            verdict_out.hit_count = src_count[hit_slot];
         end else if (free_slot >= 0) begin
            src_valid[free_slot] = 1'b1;
            src_banned[free_slot] = 1'b0;
            src_addr[free_slot] = addr;
            src_count[free_slot] = COUNT_W'(1);
            verdict_out.hit_count = COUNT_W'(1);
         end else begin
            verdict_out.untracked = 1'b1;
         end
      end
      return verdict_out;
   endfunction

   function automatic int draw_wait(input int ceiling);
      return (ceiling == 0) ? 0 : $urandom_range(0, ceiling);
   endfunction

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
   endtask

   // request driver: presents the head of the backlog, pops it on transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         hold_cycles = 0;
      end else if (!(req_valid && !req_ready)) begin
         if (req_valid) begin
            due_verdicts.push_back(judge_request(req_kind_type'(req_type), req_source_addr));
            void'(req_backlog.pop_front());
            hold_cycles = draw_wait(send_wait_max);
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            req_valid <= 1'b0;
         end else if (req_backlog.size() > 0) begin
            req_valid <= 1'b1;
            req_type <= req_backlog[0].kind;
            req_source_addr <= req_backlog[0].addr;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor: random stalls, field by field compare with the oldest verdict due
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_verdicts.size() == 0) begin
               flag_mismatch("result transfer with no request outstanding");
            end else begin
               due_head = due_verdicts.pop_front();
               if (rsp_verdict !== due_head.verdict)
                  flag_mismatch($sformatf("verdict got %b want %b",
                                          rsp_verdict, due_head.verdict));
               if (rsp_ban_now !== due_head.ban_now)
                  flag_mismatch($sformatf("ban_now got %b want %b",
                                          rsp_ban_now, due_head.ban_now));
               if (rsp_untracked !== due_head.untracked)
                  flag_mismatch($sformatf("untracked got %b want %b",
                                          rsp_untracked, due_head.untracked));
               if (rsp_window_cleared !== due_head.window_cleared)
                  flag_mismatch($sformatf("window_cleared got %b want %b",
                                          rsp_window_cleared, due_head.window_cleared));
               if (rsp_hit_count !== due_head.hit_count)
                  flag_mismatch($sformatf("hit_count got %0d want %0d",
                                          rsp_hit_count, due_head.hit_count));
            end
            stall_cycles = draw_wait(sink_wait_max);
         end
         if (stall_cycles > 0) begin
            stall_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic enqueue(input req_kind_type kind, input logic [ADDR_W-1:0] addr);
      query_item_type item;
      item.kind = kind;
      item.addr = addr;
      req_backlog.push_back(item);
   endtask

   // hold off until every request has been answered
   task automatic wait_drained();
      do @(posedge clock);
      while (req_backlog.size() != 0 || due_verdicts.size() != 0);
   endtask

   // register write, only issued while the limiter is idle
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_FLOOD_THRESHOLD) limit_threshold = data;
      else if (idx == CSR_WINDOW_TICKS) limit_window = data;
   endtask

   function automatic logic [ADDR_W-1:0] pick_source();
      if ($urandom_range(0, 99) < 85) return addr_pool[$urandom_range(0, pool_size - 1)];
      return $urandom;
   endfunction

   // stimulus sequence
   initial begin
      int phase;
      int sent;
      int chunk;
      int tick_odds;
      int k;
      logic [THRESH_W-1:0] thresh_pick;
      logic [TICK_W-1:0]   window_pick;

      for (k = 0; k < TABLE_DEPTH; k++) begin
         src_valid[k] = 1'b0;
         src_banned[k] = 1'b0;
      end
      ticks_seen = '0;
      limit_threshold = FLOOD_THRESHOLD_RESET;
      limit_window = WINDOW_TICKS_RESET;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, address extremes, neighbors differing in one bit
      enqueue(KIND_QUERY, 32'h0000_0000);
      enqueue(KIND_QUERY, 32'hFFFF_FFFF);
      enqueue(KIND_QUERY, 32'h0000_0000);
      enqueue(KIND_QUERY, 32'h0000_0001);
      enqueue(KIND_QUERY, 32'h8000_0000);
      enqueue(KIND_TICK, 32'h0000_0000);
      enqueue(KIND_TICK, 32'hFFFF_FFFF);
      wait_drained();

      // threshold of zero bans on the second query; third tick closes the window
      write_csr(CSR_FLOOD_THRESHOLD, 16'd0);
      write_csr(CSR_WINDOW_TICKS, 16'd3);
      enqueue(KIND_QUERY, 32'h0000_0000);
      enqueue(KIND_QUERY, 32'h0000_0000);
      enqueue(KIND_QUERY, 32'hA5A5_A5A5);
      enqueue(KIND_QUERY, 32'hA5A5_A5A5);
      enqueue(KIND_TICK, 32'h1234_5678);
      enqueue(KIND_QUERY, 32'h0000_0000);
      wait_drained();

      // window of zero clears on every tick, threshold one
      write_csr(CSR_WINDOW_TICKS, 16'd0);
      write_csr(CSR_FLOOD_THRESHOLD, 16'd1);
      enqueue(KIND_TICK, 32'h0);
      enqueue(KIND_QUERY, 32'h5A5A_5A5A);
      enqueue(KIND_QUERY, 32'h5A5A_5A5A);
      enqueue(KIND_QUERY, 32'h5A5A_5A5A);
      enqueue(KIND_TICK, 32'h0);
      wait_drained();

      // spare index must leave both registers alone
      write_csr(CSR_SPARE_INDEX, 16'hFFFF);
      enqueue(KIND_QUERY, 32'h5A5A_5A5A);
      enqueue(KIND_TICK, 32'h0);
      wait_drained();

      // back-to-back burst: one source runs past the threshold,
      // the table overflows, and the window closes on its last tick
      send_wait_max = 0;
      sink_wait_max = 0;
      write_csr(CSR_FLOOD_THRESHOLD, 16'd40);
      write_csr(CSR_WINDOW_TICKS, 16'd50);
      for (k = 0; k < 42; k++) enqueue(KIND_QUERY, 32'hC0A8_0001);
      for (k = 0; k < 70; k++) enqueue(KIND_QUERY, 32'h0A00_0000 + ADDR_W'(k));
      for (k = 0; k < 50; k++) enqueue(KIND_TICK, $urandom);
      enqueue(KIND_QUERY, 32'hC0A8_0001);
      wait_drained();

      // random phases, each with its own settings and address pool
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               thresh_pick = THRESH_W'($urandom_range(1, 8));
               window_pick = TICK_W'($urandom_range(20, 60));
               tick_odds = 10;
               pool_size = 40;
            end
            1: begin
               thresh_pick = 16'd0;
               window_pick = 16'd1;
               tick_odds = 15;
               pool_size = 70;
            end
            2: begin
               thresh_pick = THRESH_W'($urandom_range(2, 20));
               window_pick = 16'hFFFF;
               tick_odds = 40;
               pool_size = 100;
            end
            default: begin
               thresh_pick = THRESH_W'($urandom_range(0, 3));
               window_pick = 16'd0;
               tick_odds = 25;
               pool_size = 60;
            end
         endcase
         write_csr(CSR_FLOOD_THRESHOLD, thresh_pick);
         write_csr(CSR_WINDOW_TICKS, window_pick);

         // pool with some near neighbors to stress the address compare
         for (k = 0; k < pool_size; k++) begin
            if (k > 0 && $urandom_range(0, 3) == 0)
               addr_pool[k] = addr_pool[k - 1] ^ (32'h1 << $urandom_range(0, 31));
            else
               addr_pool[k] = $urandom;
         end

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            chunk = $urandom_range(30, 120);
            case ($urandom_range(0, 4))
               0: begin send_wait_max = 0;  sink_wait_max = 0;  end
               1: begin send_wait_max = 18; sink_wait_max = 0;  end
               2: begin send_wait_max = 0;  sink_wait_max = 18; end
               3: begin send_wait_max = 3;  sink_wait_max = 3;  end
               default: begin send_wait_max = 18; sink_wait_max = 18; end
            endcase
            for (k = 0; k < chunk; k++) begin
               if ($urandom_range(1, tick_odds) == 1) enqueue(KIND_TICK, $urandom);
               else enqueue(KIND_QUERY, pick_source());
            end
            sent += chunk;
            if ($urandom_range(0, 1) == 0) begin
               wait_drained();
            end else begin
               do @(posedge clock);
               while (req_backlog.size() > 8);
            end
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("per_source_query_flood_limiter_core verification clean");
      end else begin
         $display("per_source_query_flood_limiter_core verification failed");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/pqfl_pkg.sv
hw/rtl/pqfl_match.sv
hw/rtl/pqfl_update.sv
hw/rtl/per_source_query_flood_limiter_core.sv
hw/rtl/pqfl_checker.sv
test/tb_per_source_query_flood_limiter_core.sv
